FILE: design/rcd_pkg.sv
// shared constants, types and index helpers for the restricted circular deque
package rcd_pkg;

    localparam int DEPTH    = 8;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int WORD_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;

    localparam logic [KIND_W-1:0] KIND_INS_REAR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REM_FRONT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REM_REAR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LIST      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOWED = 3'd4;

    localparam logic MODE_INPUT_RESTRICTED  = 1'b0;
    localparam logic MODE_OUTPUT_RESTRICTED = 1'b1;

    typedef enum logic [1:0] {
        OUTC_ERROR,
        OUTC_INSERT,
        OUTC_REMOVE,
        OUTC_LIST
    } outcome_t;

    typedef struct packed {
        logic load_item;
        logic exec_insert;
        logic exec_remove;
        logic list_start;
        logic list_next;
        logic out_err;
        logic out_ins_ok;
        logic out_read;
    } dp_cmd_t;

    typedef struct packed {
        outcome_t outcome;
        logic     last;
    } dp_stat_t;

    function automatic logic [IDX_W-1:0] idx_up(input logic [IDX_W-1:0] i);
        idx_up = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_down(input logic [IDX_W-1:0] i);
        idx_down = (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

endpackage

FILE: design/rcd_ram.sv
// generic single-write, single-read ram with registered read data
module rcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/rcd_datapath.sv
// deque datapath: indices, element count, slot ram, mode register and result word
module rcd_datapath
    import rcd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_cmd_t                    cmd,
    output dp_stat_t                   stat,
    input  logic                       cfg_write,
    input  logic                       cfg_mode,
    input  logic [KIND_W-1:0]          kind,
    input  logic signed [WORD_W-1:0]   value,
    output logic [STATUS_W-1:0]        status,
    output logic signed [WORD_W-1:0]   data,
    output logic                       last
);

    logic                  mode_reg, mode_next;
    logic [IDX_W-1:0]      front_reg, front_next;
    logic [IDX_W-1:0]      rear_reg, rear_next;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      remain_reg, remain_next;
    logic                  listing_reg, listing_next;

    logic [KIND_W-1:0]     kind_reg;
    logic [WORD_W-1:0]     value_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [WORD_W-1:0]     data_reg;
    logic                  last_reg;

    logic                  ram_we;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_waddr;
    logic [IDX_W-1:0]      ram_raddr;
    logic [WORD_W-1:0]     ram_rdata;

    logic                  is_empty;
    logic                  is_full;
    outcome_t              outcome;
    logic [STATUS_W-1:0]   err_status;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));

    // classify the held item
    always_comb
    begin
        outcome    = OUTC_ERROR;
        err_status = ST_NOT_ALLOWED;
        unique case (kind_reg)
            KIND_INS_REAR, KIND_INS_FRONT:
            begin
                if (kind_reg == KIND_INS_FRONT && mode_reg == MODE_INPUT_RESTRICTED)
                begin
                    err_status = ST_NOT_ALLOWED;
                end
                else if (is_full)
                begin
                    err_status = ST_OVERFLOW;
                end
                else
                begin
                    outcome = OUTC_INSERT;
                end
            end
            KIND_REM_FRONT, KIND_REM_REAR:
            begin
                if (kind_reg == KIND_REM_REAR && mode_reg == MODE_OUTPUT_RESTRICTED)
                begin
                    err_status = ST_NOT_ALLOWED;
                end
                else if (is_empty)
                begin
                    err_status = ST_UNDERFLOW;
                end
                else
                begin
                    outcome = OUTC_REMOVE;
                end
            end
            KIND_LIST:
            begin
                if (is_empty)
                begin
                    err_status = ST_EMPTY;
                end
                else
                begin
                    outcome = OUTC_LIST;
                end
            end
            default:
            begin
                err_status = ST_NOT_ALLOWED;
            end
        endcase
    end

    always_comb
    begin
        mode_next    = mode_reg;
        front_next   = front_reg;
        rear_next    = rear_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        remain_next  = remain_reg;
        listing_next = listing_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = '0;
        ram_raddr    = pos_reg;

        if (cfg_write)
        begin
            mode_next = cfg_mode;
        end

        if (cmd.exec_insert)
        begin
            ram_we = 1'b1;
            if (is_empty)
            begin
                ram_waddr  = '0;
                front_next = '0;
                rear_next  = '0;
            end
            else if (kind_reg == KIND_INS_REAR)
            begin
                ram_waddr = idx_up(rear_reg);
                rear_next = ram_waddr;
            end
            else
            begin
                ram_waddr  = idx_down(front_reg);
                front_next = ram_waddr;
            end
            count_next = count_reg + 1'b1;
        end

        if (cmd.exec_remove)
        begin
            ram_re       = 1'b1;
            listing_next = 1'b0;
            if (kind_reg == KIND_REM_FRONT)
            begin
                ram_raddr  = front_reg;
                front_next = idx_up(front_reg);
            end
            else
            begin
                ram_raddr = rear_reg;
                rear_next = idx_down(rear_reg);
            end
            count_next = count_reg - 1'b1;
            // last element gone: both indices back to zero
            if (count_reg == CNT_W'(1))
            begin
                front_next = '0;
                rear_next  = '0;
            end
        end

        if (cmd.list_start)
        begin
            ram_re       = 1'b1;
            ram_raddr    = front_reg;
            pos_next     = idx_up(front_reg);
            remain_next  = count_reg;
            listing_next = 1'b1;
        end

        if (cmd.list_next)
        begin
            ram_re    = 1'b1;
            ram_raddr = pos_reg;
            pos_next  = idx_up(pos_reg);
        end

        if (cmd.out_read && listing_reg)
        begin
            remain_next = remain_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_INPUT_RESTRICTED;
            front_reg   <= '0;
            rear_reg    <= '0;
            pos_reg     <= '0;
            count_reg   <= '0;
            remain_reg  <= '0;
            listing_reg <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            front_reg   <= front_next;
            rear_reg    <= rear_next;
            pos_reg     <= pos_next;
            count_reg   <= count_next;
            remain_reg  <= remain_next;
            listing_reg <= listing_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg  <= kind;
            value_reg <= $unsigned(value);
        end
        if (cmd.out_err)
        begin
            status_reg <= err_status;
            data_reg   <= '0;
            last_reg   <= 1'b1;
        end
        else if (cmd.out_ins_ok)
        begin
            status_reg <= ST_OK;
            data_reg   <= '0;
            last_reg   <= 1'b1;
        end
        else if (cmd.out_read)
        begin
            status_reg <= ST_OK;
            data_reg   <= ram_rdata;
            last_reg   <= !listing_reg || (remain_reg == CNT_W'(1));
        end
    end

    rcd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign stat.outcome = outcome;
    assign stat.last    = last_reg;
    assign status       = status_reg;
    assign data         = $signed(data_reg);
    assign last         = last_reg;

endmodule

FILE: design/rcd_ctrl.sv
// deque controller: sequences accept, execute, slot read and result hand-off
module rcd_ctrl
    import rcd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_SEND
    } state_t;

    state_t state_reg, state_next;
    logic   in_stall_reg, in_stall_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        in_stall_next  = in_stall_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    in_stall_next = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (stat.outcome)
                    OUTC_ERROR:
                    begin
                        cmd.out_err    = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = S_SEND;
                    end
                    OUTC_INSERT:
                    begin
                        cmd.exec_insert = 1'b1;
                        cmd.out_ins_ok  = 1'b1;
                        out_valid_next  = 1'b1;
                        state_next      = S_SEND;
                    end
                    OUTC_REMOVE:
                    begin
                        cmd.exec_remove = 1'b1;
                        state_next      = S_FETCH;
                    end
                    default:
                    begin
                        cmd.list_start = 1'b1;
                        state_next     = S_FETCH;
                    end
                endcase
            end
            S_FETCH:
            begin
                cmd.out_read   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_SEND;
            end
            default:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (stat.last)
                    begin
                        in_stall_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        cmd.list_next = 1'b1;
                        state_next    = S_FETCH;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_stall_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_stall_reg  <= in_stall_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = in_stall_reg;
    assign out_valid = out_valid_reg;

endmodule

FILE: design/restricted_circular_deque.sv
// top level of the restricted circular deque
// One word at a time. An insert, a refused operation or an error result puts its result
// word on the output from the result registers loaded in the S_EXEC state. A removal
// goes through S_EXEC and then S_FETCH, which holds the registered read of the slot ram.
// A listing of n elements gives its first word along the same path. After that it gives
// one more word after each word is taken, each word paced by one slot ram read. in_stall
// goes low again in the cycle after the last result word of an item is taken. restriction_mode
// may be written at any cycle (cfg_ready is always high) but should only change while no
// item is in progress.
module restricted_circular_deque
    import rcd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [KIND_W-1:0]        kind,
    input  logic signed [WORD_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic signed [WORD_W-1:0] data,
    output logic                     last,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     restriction_mode
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    rcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    rcd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_mode  (restriction_mode),
        .kind      (kind),
        .value     (value),
        .status    (status),
        .data      (data),
        .last      (last)
    );

endmodule
